/* rtl/dds_pkg.sv */
package dds_pkg;

   // Graph size and field widths
   localparam int MAX_VERTICES = 16;
   localparam int VIDX_W = $clog2(MAX_VERTICES);
   localparam int EADDR_W = 2 * VIDX_W;
   localparam int EDGE_DEPTH = MAX_VERTICES * MAX_VERTICES;
   localparam int WEIGHT_W = 16;
   localparam int DIST_W = 31;
   localparam int CNT_W = 5;

   // Largest vertex count a run reports on
   localparam int VCAP = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;

   localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};
   localparam logic [CNT_W-1:0] VCNT_RESET = CNT_W'(16);

   // Item kinds on the request channel
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_RUN = 1'b1;

   // Write port of the adjacency matrix
   typedef struct packed {
      logic en;
      logic [EADDR_W-1:0] addr;
      logic [WEIGHT_W-1:0] data;
   } edge_wr_type;

   // Write port of the distance table
   typedef struct packed {
      logic en;
      logic [VIDX_W-1:0] addr;
      logic [DIST_W-1:0] data;
   } dist_wr_type;

endpackage

/* rtl/dds_edge_store.sv */
module dds_edge_store (
   input  logic clock,
   input  dds_pkg::edge_wr_type wr,
   input  logic [dds_pkg::EADDR_W-1:0] rd_addr,
   output logic [dds_pkg::WEIGHT_W-1:0] rd_data
);

   logic [dds_pkg::WEIGHT_W-1:0] mem [dds_pkg::EDGE_DEPTH];
   logic [dds_pkg::WEIGHT_W-1:0] rd_data_ff;

   // Weight matrix, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/dds_dist_store.sv */
module dds_dist_store (
   input  logic clock,
   input  dds_pkg::dist_wr_type wr,
   input  logic [dds_pkg::VIDX_W-1:0] rd_addr,
   output logic [dds_pkg::DIST_W-1:0] rd_data
);

   logic [dds_pkg::DIST_W-1:0] mem [dds_pkg::MAX_VERTICES];
   logic [dds_pkg::DIST_W-1:0] rd_data_ff;

   // Tentative distances, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/dense_dijkstra_shortest_paths_core.sv */
// Single-source shortest paths over a dense weighted adjacency matrix held in
// an on-chip RAM. A load item (tuser = 0) writes one 16-bit weight; weight
// zero means no edge. A run item (tuser = 1) names a start vertex; the core
// then sweeps the distance RAM once per round to pick the closest unvisited
// vertex (lowest index on ties) and once more, together with that vertex's
// matrix row, to relax its neighbors. After the last round the n results
// stream out in vertex order with tlast on the final one, each loaded only
// once the output slot is free. An unreachable vertex reports 2147483647. A
// start vertex not below the vertex count gives a single result with tuser
// set. Every matrix entry in use must be loaded before a run; the vertex
// count register must be written only while the core is idle, which the
// core itself does not enforce.
module dense_dijkstra_shortest_paths_core (
   input  logic clock,
   input  logic reset,

   input  logic req_tvalid,
   output logic req_tready,
   // [3:0] row, [7:4] col, [23:8] weight, [27:24] start_vertex, [31:28] zero
   input  logic [31:0] req_tdata,
   // [0] kind
   input  logic req_tuser,

   output logic rsp_tvalid,
   input  logic rsp_tready,
   // [3:0] vertex, [34:4] distance, [39:35] zero
   output logic [39:0] rsp_tdata,
   output logic rsp_tlast,
   // [0] start_invalid
   output logic rsp_tuser,

   input  logic csr_valid,
   output logic csr_ready,
   input  logic [4:0] csr_data
);

   localparam int VW = dds_pkg::VIDX_W;
   localparam int DW = dds_pkg::DIST_W;
   localparam int CW = dds_pkg::CNT_W;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_INIT   = 3'd1;
   localparam logic [2:0] ST_SEL    = 3'd2;
   localparam logic [2:0] ST_REL    = 3'd3;
   localparam logic [2:0] ST_OUT_RD = 3'd4;
   localparam logic [2:0] ST_OUT_LD = 3'd5;
   localparam logic [2:0] ST_BAD    = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [CW-1:0] vcount_ff, vcount_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] round_ff, round_in;
   logic p_vld_ff, p_vld_in;
   logic [VW-1:0] p_idx_ff, p_idx_in;
   logic [VW-1:0] pick_ff, pick_in;
   logic [DW-1:0] least_ff, least_in;
   logic found_ff, found_in;
   logic [3:0] start_ff, start_in;
   logic [dds_pkg::MAX_VERTICES-1:0] done_ff, done_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [3:0] rsp_vertex_ff, rsp_vertex_in;
   logic [DW-1:0] rsp_dist_ff, rsp_dist_in;
   logic rsp_last_ff, rsp_last_in;
   logic rsp_inval_ff, rsp_inval_in;

   logic req_acc;
   logic [3:0] req_row, req_col, req_start;
   logic [dds_pkg::WEIGHT_W-1:0] req_weight;
   logic load_ok;
   logic [CW-1:0] n_act;
   logic issue, sweep_end, slot_free;
   logic [DW:0] sum;
   logic [DW-1:0] sum_sat;
   logic relax_upd;

   dds_pkg::edge_wr_type edge_wr;
   dds_pkg::dist_wr_type dist_wr;
   logic [dds_pkg::WEIGHT_W-1:0] edge_rdata;
   logic [DW-1:0] dist_rdata;

   // Request unpacking
   assign req_row = req_tdata[3:0];
   assign req_col = req_tdata[7:4];
   assign req_weight = req_tdata[23:8];
   assign req_start = req_tdata[27:24];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   // Loads outside the matrix are dropped
   assign load_ok = (32'(req_row) < 32'(dds_pkg::MAX_VERTICES)) &&
                    (32'(req_col) < 32'(dds_pkg::MAX_VERTICES));

   // Vertex count in use, saturated to the supported size
   assign n_act = (vcount_ff > CW'(dds_pkg::VCAP)) ? CW'(dds_pkg::VCAP) : vcount_ff;

   // Sweep control shared by selection and relaxation
   assign issue = (idx_ff < n_act);
   assign sweep_end = (idx_ff == n_act) && !p_vld_ff;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // Relaxation arithmetic on the delayed sweep element
   assign sum = {1'b0, least_ff} + (DW + 1)'(edge_rdata);
   assign sum_sat = (sum > {1'b0, dds_pkg::DIST_INF}) ? dds_pkg::DIST_INF : sum[DW-1:0];
   assign relax_upd = (state_ff == ST_REL) && p_vld_ff && !done_ff[p_idx_ff] &&
                      (edge_rdata != '0) && (sum_sat < dist_rdata);

   // Memory ports
   assign edge_wr.en = req_acc && (req_tuser == dds_pkg::KIND_LOAD) && load_ok;
   assign edge_wr.addr = {VW'(req_row), VW'(req_col)};
   assign edge_wr.data = req_weight;

   always_comb begin
      dist_wr.en = 1'b0;
      dist_wr.addr = p_idx_ff;
      dist_wr.data = sum_sat;
      if (state_ff == ST_INIT) begin
         dist_wr.en = 1'b1;
         dist_wr.addr = VW'(idx_ff);
         dist_wr.data = (VW'(idx_ff) == VW'(start_ff)) ? '0 : dds_pkg::DIST_INF;
      end else if (relax_upd) begin
         dist_wr.en = 1'b1;
      end
   end

   dds_edge_store u_edge (
      .clock   (clock),
      .wr      (edge_wr),
      .rd_addr ({pick_ff, VW'(idx_ff)}),
      .rd_data (edge_rdata)
   );

   dds_dist_store u_dist (
      .clock   (clock),
      .wr      (dist_wr),
      .rd_addr (VW'(idx_ff)),
      .rd_data (dist_rdata)
   );

   // Sequencer
   always_comb begin
      state_in = state_ff;
      vcount_in = vcount_ff;
      idx_in = idx_ff;
      round_in = round_ff;
      p_vld_in = 1'b0;
      p_idx_in = VW'(idx_ff);
      pick_in = pick_ff;
      least_in = least_ff;
      found_in = found_ff;
      start_in = start_ff;
      done_in = done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_dist_in = rsp_dist_ff;
      rsp_last_in = rsp_last_ff;
      rsp_inval_in = rsp_inval_ff;

      if (csr_valid && csr_ready) begin
         vcount_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_tuser == dds_pkg::KIND_RUN)) begin
               start_in = req_start;
               idx_in = '0;
               round_in = '0;
               done_in = '0;
               if (CW'(req_start) >= n_act) begin
                  state_in = ST_BAD;
               end else begin
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            idx_in = idx_ff + 1'b1;
            least_in = dds_pkg::DIST_INF;
            found_in = 1'b0;
            if (CW'(idx_ff + 1'b1) == n_act) begin
               idx_in = '0;
               state_in = (n_act == CW'(1)) ? ST_OUT_RD : ST_SEL;
            end
         end
         ST_SEL: begin
            if (issue) begin
               p_vld_in = 1'b1;
               idx_in = idx_ff + 1'b1;
            end
            if (p_vld_ff && !done_ff[p_idx_ff] && (dist_rdata < least_ff)) begin
               least_in = dist_rdata;
               pick_in = p_idx_ff;
               found_in = 1'b1;
            end
            if (sweep_end) begin
               idx_in = '0;
               if (found_ff) begin
                  done_in[pick_ff] = 1'b1;
                  state_in = ST_REL;
               end else begin
                  state_in = ST_OUT_RD;
               end
            end
         end
         ST_REL: begin
            if (issue) begin
               p_vld_in = 1'b1;
               idx_in = idx_ff + 1'b1;
            end
            if (sweep_end) begin
               idx_in = '0;
               round_in = round_ff + 1'b1;
               least_in = dds_pkg::DIST_INF;
               found_in = 1'b0;
               if (CW'(round_ff + CW'(2)) == n_act) begin
                  state_in = ST_OUT_RD;
               end else begin
                  state_in = ST_SEL;
               end
            end
         end
         ST_OUT_RD: begin
            // Distance read is issued once the output slot frees up
            if (slot_free) begin
               state_in = ST_OUT_LD;
            end
         end
         ST_OUT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_vertex_in = 4'(idx_ff);
            rsp_dist_in = dist_rdata;
            rsp_last_in = (CW'(idx_ff + 1'b1) == n_act);
            rsp_inval_in = 1'b0;
            if (CW'(idx_ff + 1'b1) == n_act) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = ST_OUT_RD;
            end
         end
         ST_BAD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_vertex_in = start_ff;
               rsp_dist_in = dds_pkg::DIST_INF;
               rsp_last_in = 1'b1;
               rsp_inval_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vcount_ff <= dds_pkg::VCNT_RESET;
         idx_ff <= '0;
         round_ff <= '0;
         p_vld_ff <= 1'b0;
         found_ff <= 1'b0;
         done_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vcount_ff <= vcount_in;
         idx_ff <= idx_in;
         round_ff <= round_in;
         p_vld_ff <= p_vld_in;
         found_ff <= found_in;
         done_ff <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      p_idx_ff <= p_idx_in;
      pick_ff <= pick_in;
      least_ff <= least_in;
      start_ff <= start_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_last_ff <= rsp_last_in;
      rsp_inval_ff <= rsp_inval_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {5'b0, rsp_dist_ff, rsp_vertex_ff};
   assign rsp_tlast = rsp_last_ff;
   assign rsp_tuser = rsp_inval_ff;

`ifndef NO_ASSERTIONS
   // A flagged start always closes its run
   a_inval_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_inval_ff) |-> rsp_last_ff)
      else $error("start_invalid result without tlast");

   // Relaxation always works from a vertex already settled
   a_rel_pick_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REL) |-> done_ff[pick_ff])
      else $error("relaxing from an unsettled vertex");

   // A distance is loaded into the output slot only when it is empty
   a_slot_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT_LD) |-> !rsp_valid_ff)
      else $error("output slot overwritten");

   // Each selection settles exactly one new vertex
   a_one_settled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEL && sweep_end && found_ff) |=>
      ($countones(done_ff) == $countones($past(done_ff)) + 1))
      else $error("selection did not settle one vertex");
`endif

endmodule
